[design/lmb_pkg.sv]
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared widths, register codes, types and step counts for the light moving
// average to brightness block.
// ----------------------------------------------------------------------------
`default_nettype none

package lmb_pkg;

   localparam int RAW_W      = 16;  // sensor count
   localparam int LUX_W      = 15;  // lux sample, max 27306
   localparam int WINDOW     = 16;  // ring depth
   localparam int WIN_BITS   = 4;   // log2 of WINDOW
   localparam int SUM_W      = LUX_W + WIN_BITS;
   localparam int SPAN_W     = 16;  // lux span registers
   localparam int BR_W       = 8;   // brightness
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // lux = floor(floor(count * 5 / 4) / 3), dividend is RAW_W + 1 bits wide
   localparam int LUX_STEPS  = RAW_W + 1;
   localparam int LUX_CNT_W  = 5;

   // map unit: shift-add multiply, then restoring divide
   localparam int MUL_STEPS  = BR_W;
   localparam int PROD_W     = SPAN_W + BR_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int MAP_STEPS  = MUL_STEPS + DIV_STEPS;
   localparam int MAP_CNT_W  = 5;
   localparam int VAL_W      = PROD_W + 2;

   localparam logic [CSR_IDX_W-1:0] REG_LUX_LO = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LUX_HI = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BR_LO  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_BR_HI  = CSR_IDX_W'(3);

   localparam logic [SPAN_W-1:0] LUX_LO_RST = SPAN_W'(0);
   localparam logic [SPAN_W-1:0] LUX_HI_RST = SPAN_W'(420);
   localparam logic [BR_W-1:0]   BR_LO_RST  = BR_W'(0);
   localparam logic [BR_W-1:0]   BR_HI_RST  = BR_W'(255);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SUM,
      ST_MSTART,
      ST_MAP,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [SPAN_W-1:0] lux_lo;
      logic [SPAN_W-1:0] lux_hi;
      logic [BR_W-1:0]   br_lo;
      logic [BR_W-1:0]   br_hi;
   } cfg_type;

   typedef struct packed {
      logic             upd;
      logic             ok;
      logic [LUX_W-1:0] lux;
   } avg_ctl_type;

endpackage

`default_nettype wire

[design/lmb_intf.sv]
// ----------------------------------------------------------------------------
// lmb channel interfaces
// Valid/ready channels for sensor items, brightness results and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmb_req_if;
   logic                        valid;
   logic                        ready;
   logic [lmb_pkg::RAW_W-1:0]   raw_count;
   logic                        read_ok;

   modport source (output valid, output raw_count, output read_ok, input ready);
   modport sink   (input valid, input raw_count, input read_ok, output ready);
endinterface

interface lmb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lmb_pkg::BR_W-1:0]    brightness;

   modport source (output valid, output brightness, input ready);
   modport sink   (input valid, input brightness, output ready);
endinterface

interface lmb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lmb_pkg::CSR_IDX_W-1:0]  index;
   logic [lmb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/lmb_lux_conv.sv]
// ----------------------------------------------------------------------------
// lmb_lux_conv
// Count to lux: scale by 5/4, then a bit-serial divide by three.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_lux_conv (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lmb_pkg::RAW_W-1:0]   raw_count,
   output logic                             done,
   output logic [lmb_pkg::LUX_W-1:0]        lux
);

   localparam int DVD_W = lmb_pkg::RAW_W + 1;

   logic [lmb_pkg::RAW_W+2:0]      scaled;
   logic [DVD_W-1:0]               dvd_ff, dvd_in;
   logic [1:0]                     rem_ff, rem_in;
   logic [2:0]                     trial;
   logic                           qbit;
   logic [lmb_pkg::LUX_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   assign scaled = {raw_count, 2'b00} + {2'b00, raw_count};
   assign trial  = {rem_ff, dvd_ff[DVD_W-1]};
   assign qbit   = (trial >= 3'd3);

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // drop the two low bits: floor(x / 12) = floor(floor(x / 4) / 3)
         dvd_in  = scaled[lmb_pkg::RAW_W+2:2];
         rem_in  = 2'b00;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? 2'(trial - 3'd3) : trial[1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lmb_pkg::LUX_CNT_W'(lmb_pkg::LUX_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign lux  = dvd_ff[lmb_pkg::LUX_W-1:0];

endmodule

`default_nettype wire

[design/lmb_avg.sv]
// ----------------------------------------------------------------------------
// lmb_avg
// Sample ring with running sum; the average is the sum over the window.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_avg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lmb_pkg::avg_ctl_type  ctl,
   output logic [lmb_pkg::LUX_W-1:0]  avg
);

   logic [lmb_pkg::LUX_W-1:0]    ring_ff [lmb_pkg::WINDOW];
   logic [lmb_pkg::WIN_BITS-1:0] ptr_ff, ptr_in;
   logic [lmb_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [lmb_pkg::LUX_W-1:0]    old_val;
   logic [lmb_pkg::LUX_W-1:0]    slot_in;

   assign old_val = ring_ff[ptr_ff];
   // failed read: keep the old slot value
   assign slot_in = ctl.ok ? ctl.lux : old_val;

   always_comb begin
      sum_in = sum_ff;
      ptr_in = ptr_ff;
      if (ctl.upd) begin
         sum_in = sum_ff - {{lmb_pkg::WIN_BITS{1'b0}}, old_val}
                         + {{lmb_pkg::WIN_BITS{1'b0}}, slot_in};
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lmb_pkg::WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff <= '0;
         ptr_ff <= '0;
      end else begin
         if (ctl.upd) begin
            ring_ff[ptr_ff] <= slot_in;
         end
         sum_ff <= sum_in;
         ptr_ff <= ptr_in;
      end
   end

   assign avg = sum_ff[lmb_pkg::SUM_W-1:lmb_pkg::WIN_BITS];

endmodule

`default_nettype wire

[design/lmb_map.sv]
// ----------------------------------------------------------------------------
// lmb_map
// Linear map of the average onto the brightness span with clamp: serial
// shift-add multiply, restoring divide one bit per cycle, then sign and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_map (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire lmb_pkg::cfg_type          cfg,
   input  wire logic [lmb_pkg::LUX_W-1:0] avg,
   output logic                           done,
   output logic [lmb_pkg::BR_W-1:0]       brightness
);

   localparam int SW = lmb_pkg::SPAN_W;
   localparam int BW = lmb_pkg::BR_W;
   localparam int PW = lmb_pkg::PROD_W;
   localparam int VW = lmb_pkg::VAL_W;

   logic signed [SW:0]   dx, span;
   logic signed [BW:0]   dy;
   logic [SW:0]          dx_mag, span_mag;
   logic [BW:0]          dy_mag;

   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [BW-1:0]        mplr_ff, mplr_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [SW-1:0]        dvs_ff, dvs_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [lmb_pkg::MAP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [SW:0]          trial;
   logic                 ge;

   logic signed [VW-1:0] q_mag, q_sgn, v_raw, v_lo, v_clamp, lo_ext, hi_ext;

   assign dx   = $signed({2'b00, avg}) - $signed({1'b0, cfg.lux_lo});
   assign span = $signed({1'b0, cfg.lux_hi}) - $signed({1'b0, cfg.lux_lo});
   assign dy   = $signed({1'b0, cfg.br_hi}) - $signed({1'b0, cfg.br_lo});

   assign dx_mag   = dx[SW]   ? (SW+1)'(-dx)   : dx;
   assign span_mag = span[SW] ? (SW+1)'(-span) : span;
   assign dy_mag   = dy[BW]   ? (BW+1)'(-dy)   : dy;

   assign trial = {rem_ff, acc_ff[PW-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      acc_in   = acc_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = {{(PW-SW){1'b0}}, dx_mag[SW-1:0]};
         mplr_in  = dy_mag[BW-1:0];
         acc_in   = '0;
         dvs_in   = span_mag[SW-1:0];
         rem_in   = '0;
         neg_in   = dx[SW] ^ dy[BW] ^ span[SW];
         zero_in  = (span == '0);
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff < lmb_pkg::MAP_CNT_W'(lmb_pkg::MUL_STEPS)) begin
            if (mplr_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[PW-2:0], 1'b0};
            mplr_in  = {1'b0, mplr_ff[BW-1:1]};
         end else begin
            // accumulator turns into the quotient, one bit per step
            rem_in = ge ? SW'(trial - {1'b0, dvs_ff}) : trial[SW-1:0];
            acc_in = {acc_ff[PW-2:0], ge};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lmb_pkg::MAP_CNT_W'(lmb_pkg::MAP_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      acc_ff   <= acc_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
   end

   // truncate toward zero, offset, then raise to low and lower to high
   assign lo_ext = $signed({{(VW-BW){1'b0}}, cfg.br_lo});
   assign hi_ext = $signed({{(VW-BW){1'b0}}, cfg.br_hi});
   assign q_mag  = $signed({2'b00, acc_ff});
   assign q_sgn  = neg_ff ? -q_mag : q_mag;

   always_comb begin
      v_raw   = zero_ff ? lo_ext : (q_sgn + lo_ext);
      v_lo    = (v_raw < lo_ext) ? lo_ext : v_raw;
      v_clamp = (v_lo > hi_ext) ? hi_ext : v_lo;
   end

   assign done       = done_ff;
   assign brightness = v_clamp[BW-1:0];

endmodule

`default_nettype wire

[design/light_moving_average_to_brightness_top.sv]
// ----------------------------------------------------------------------------
// light_moving_average_to_brightness_top
// Sensor count to lux, windowed average, linear map and clamp to brightness.
//
//   Channel  Dir  Payload                      Handshake
//   req_ch   in   raw_count[15:0], read_ok     valid/ready
//   rsp_ch   out  brightness[7:0]              valid/ready, registered
//   csr_ch   in   index[7:0], data[15:0]       valid/ready, ready always high
//
// A transaction passes the serial divide by three (17 steps), the ring update,
// the map unit (8 multiply, 24 divide steps) and the output register. The
// next request is taken the cycle after the result moves to the output
// register. A stalled result waits in the output register; the engine parks
// a further result until that register frees.
// Reset clears the ring, sum, pointer and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module light_moving_average_to_brightness_top (
   input  wire logic  clock,
   input  wire logic  reset,
   lmb_req_if.sink    req_ch,
   lmb_rsp_if.source  rsp_ch,
   lmb_csr_if.sink    csr_ch
);

   lmb_pkg::state_type   state_ff, state_in;
   lmb_pkg::cfg_type     cfg_ff, cfg_in;
   lmb_pkg::avg_ctl_type avg_ctl;

   logic                        ok_ff, ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lmb_pkg::BR_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                        req_take;
   logic                        conv_start, conv_done;
   logic [lmb_pkg::LUX_W-1:0]   lux;
   logic [lmb_pkg::LUX_W-1:0]   avg;
   logic                        avg_upd;
   logic                        map_start, map_done;
   logic [lmb_pkg::BR_W-1:0]    map_brightness;
   logic                        out_free;
   logic                        load_rsp;
   logic                        req_ready;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ready;

   lmb_lux_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .raw_count (req_ch.raw_count),
      .done      (conv_done),
      .lux       (lux)
   );

   lmb_avg u_avg (
      .clock (clock),
      .reset (reset),
      .ctl   (avg_ctl),
      .avg   (avg)
   );

   lmb_map u_map (
      .clock      (clock),
      .reset      (reset),
      .start      (map_start),
      .cfg        (cfg_ff),
      .avg        (avg),
      .done       (map_done),
      .brightness (map_brightness)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmb_pkg::ST_IDLE:   if (req_ch.valid) state_in = lmb_pkg::ST_CONV;
         lmb_pkg::ST_CONV:   if (conv_done) state_in = lmb_pkg::ST_SUM;
         lmb_pkg::ST_SUM:    state_in = lmb_pkg::ST_MSTART;
         lmb_pkg::ST_MSTART: state_in = lmb_pkg::ST_MAP;
         lmb_pkg::ST_MAP: begin
            if (map_done) begin
               state_in = out_free ? lmb_pkg::ST_IDLE : lmb_pkg::ST_HOLD;
            end
         end
         lmb_pkg::ST_HOLD:   if (out_free) state_in = lmb_pkg::ST_IDLE;
         default:            state_in = lmb_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      avg_upd   = 1'b0;
      map_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         lmb_pkg::ST_IDLE:   req_ready = 1'b1;
         lmb_pkg::ST_CONV:   ;
         lmb_pkg::ST_SUM:    avg_upd   = 1'b1;
         lmb_pkg::ST_MSTART: map_start = 1'b1;
         lmb_pkg::ST_MAP:    load_rsp  = map_done && out_free;
         lmb_pkg::ST_HOLD:   load_rsp  = out_free;
         default:            ;
      endcase
   end

   assign conv_start  = req_take;
   assign avg_ctl.upd = avg_upd;
   assign avg_ctl.ok  = ok_ff;
   assign avg_ctl.lux = lux;
   assign ok_in       = req_take ? req_ch.read_ok : ok_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = map_brightness;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes; unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            lmb_pkg::REG_LUX_LO: cfg_in.lux_lo = csr_ch.data;
            lmb_pkg::REG_LUX_HI: cfg_in.lux_hi = csr_ch.data;
            lmb_pkg::REG_BR_LO:  cfg_in.br_lo  = csr_ch.data[lmb_pkg::BR_W-1:0];
            lmb_pkg::REG_BR_HI:  cfg_in.br_hi  = csr_ch.data[lmb_pkg::BR_W-1:0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lmb_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cfg_ff.lux_lo <= lmb_pkg::LUX_LO_RST;
         cfg_ff.lux_hi <= lmb_pkg::LUX_HI_RST;
         cfg_ff.br_lo  <= lmb_pkg::BR_LO_RST;
         cfg_ff.br_hi  <= lmb_pkg::BR_HI_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready      = req_ready;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.brightness = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_conv_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == lmb_pkg::ST_CONV))
      else $error("lux converter finished outside the conversion state");

   a_map_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_done |-> (state_ff == lmb_pkg::ST_MAP))
      else $error("map unit finished outside the map state");

   a_hold_means_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lmb_pkg::ST_HOLD) |-> rsp_valid_ff)
      else $error("result parked while output register is empty");

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == lmb_pkg::ST_CONV))
      else $error("accepted transaction did not start conversion");
`endif

endmodule

`default_nettype wire
